/* hw/rtl/lsm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_pkg: shared types, constants and table functions
// Constants, queue entry type and the exp and log2 lookup tables.
// ----------------------------------------------------------------------------
package lsm_pkg;

	localparam int MAX_VOCAB       = 262144;
	localparam int EXP_TABLE_DEPTH = 256;
	localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
	localparam int VOCAB_W         = 19;
	localparam int IDX_W           = 18;
	localparam int SUM_W           = 40;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [15:0] LN2_Q16 = 16'd45426;
	localparam logic [VOCAB_W-1:0] VOCAB_RESET = 19'd32000;
	localparam logic [1:0] REG_VOCAB = 2'd0;

	// queue entry from front to back
	typedef struct packed {
		logic signed [15:0] logit;
		logic               first;     // element index zero
		logic               hit;       // element index equals target
		logic               row_end;
		logic               bad_tgt;   // target not below row length
		logic               last_row;
	} lsm_item_t;

	// queue status towards the front
	typedef struct packed {
		logic full;
		logic empty;
	} lsm_qstat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EXP,
		BK_LN,
		BK_OUT
	} lsm_bk_state_t;

	// 2^(-k/DEPTH) in Q16
	function automatic logic [16:0] exp_entry(input int unsigned k);
		logic [63:0] y, term, acc;
		logic [63:0] acc_s;
		y = (64'(k) * 64'd744261118) / 64'(EXP_TABLE_DEPTH);
		term = 64'd1 << 30;
		acc = term;
		for (int n = 1; n <= 13; n++) begin
			term = ((term * y) >> 30) / 64'(n);
			if ((n % 2) == 1) acc = acc - term;
			else acc = acc + term;
		end
		if (acc[63]) acc = 64'd0;
		acc_s = (acc + 64'd8192) >> 14;
		return acc_s[16:0];
	endfunction

	// log2(1 + k/256) in Q24
	function automatic logic [23:0] log2_entry(input int unsigned k);
		logic [63:0] x;
		logic [23:0] r;
		x = 64'(256 + k) << 22;
		r = '0;
		for (int i = 0; i < 24; i++) begin
			x = (x * x) >> 30;
			if (x >= (64'd2 << 30)) begin
				x = x >> 1;
				r[23-i] = 1'b1;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/lsm_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_in_if / lsm_out_if: valid-ready channels
// Input item channel and result channel with source and sink modports.
// ----------------------------------------------------------------------------
interface lsm_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] logit;
	logic [17:0]        target_token;
	logic               last_row;
	modport source (output valid, logit, target_token, last_row, input ready);
	modport sink (input valid, logit, target_token, last_row, output ready);
endinterface

interface lsm_out_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] row_logprob;
	logic signed [31:0] total_logprob;
	logic               target_out_of_range;
	logic               last;
	modport source (output valid, row_logprob, total_logprob, target_out_of_range, last,
		input ready);
	modport sink (input valid, row_logprob, total_logprob, target_out_of_range, last,
		output ready);
endinterface
`default_nettype wire

/* hw/rtl/lsm_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_front: item intake and classification
// Tracks element index, marks row start/end, target hit and bad target.
// ----------------------------------------------------------------------------
module lsm_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	lsm_in_if.sink                            in_ch,
	input  wire logic [lsm_pkg::VOCAB_W-1:0]  vocab_size,
	input  wire lsm_pkg::lsm_qstat_t          qstat,
	output lsm_pkg::lsm_item_t                item,
	output logic                              push
);
	import lsm_pkg::*;

	logic [IDX_W-1:0]   idx_q;
	logic [VOCAB_W-1:0] vlen;
	logic [VOCAB_W-1:0] idx_p1;
	logic               row_end;

	// clamp row length to [1, MAX_VOCAB]
	always_comb begin
		vlen = vocab_size;
		if (vlen == '0) vlen = VOCAB_W'(1);
		if (vlen > VOCAB_W'(MAX_VOCAB)) vlen = VOCAB_W'(MAX_VOCAB);
	end

	assign idx_p1  = {1'b0, idx_q} + VOCAB_W'(1);
	assign row_end = idx_p1 >= vlen;

	assign in_ch.ready = !qstat.full;
	assign push        = in_ch.valid && in_ch.ready;

	always_comb begin
		item.logit    = in_ch.logit;
		item.first    = idx_q == '0;
		item.hit      = idx_q == in_ch.target_token;
		item.row_end  = row_end;
		item.bad_tgt  = {1'b0, in_ch.target_token} >= vlen;
		item.last_row = in_ch.last_row;
	end

	// element counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (push) begin
			idx_q <= row_end ? '0 : idx_p1[IDX_W-1:0];
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		push && row_end |=> idx_q == '0)
		else $error("index not cleared at row end");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !push)
		else $error("push into full queue");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !row_end |=> idx_q == $past(idx_p1[IDX_W-1:0]))
		else $error("index step wrong");

endmodule
`default_nettype wire

/* hw/rtl/lsm_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_queue: four-entry item queue
// Decouples the front classification from the back arithmetic.
// ----------------------------------------------------------------------------
module lsm_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire lsm_pkg::lsm_item_t wdata,
	input  wire logic               pop,
	output lsm_pkg::lsm_item_t      rdata,
	output lsm_pkg::lsm_qstat_t     qstat
);
	import lsm_pkg::*;

	lsm_item_t  mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign rdata       = mem_q[rp_q];
	assign qstat.full  = cnt_q == 3'd4;
	assign qstat.empty = cnt_q == 3'd0;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!push && !pop |=> $stable(cnt_q))
		else $error("count moved without transfer");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("count overflow");

endmodule
`default_nettype wire

/* hw/rtl/lsm_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_back: online log-sum-exp datapath
// Running max, rescaled exp sum, target capture, ln and total per row.
// ----------------------------------------------------------------------------
module lsm_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lsm_pkg::lsm_item_t item,
	input  wire lsm_pkg::lsm_qstat_t qstat,
	output logic                    pop,
	lsm_out_if.source               out_ch
);
	import lsm_pkg::*;

	lsm_bk_state_t      st_q, st_d;
	lsm_item_t          cur_q;
	logic signed [15:0] max_q;
	logic [SUM_W-1:0]   sum_q;
	logic signed [15:0] tgt_q;
	logic               seen_q;
	logic signed [31:0] total_q;
	logic [16:0]        e_q;      // exp term, registered
	logic               up_q;     // max rises
	logic [56:0]        ln_prod_q;

	// constant exp and log2 tables
	logic [16:0] exp_rom [EXP_TABLE_DEPTH];
	logic [23:0] ln_rom [256];
	always_comb begin
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) exp_rom[k] = exp_entry(k);
		for (int k = 0; k < 256; k++) ln_rom[k] = log2_entry(k);
	end

	// exp of the difference: multiply, then table and shift
	logic [16:0] diff;
	logic [33:0] t_prod;
	logic [9:0]  ip;
	logic [EXP_IDX_W-1:0] eidx;
	logic [16:0] e_val;
	always_comb begin
		if ($signed(item.logit) > max_q) diff = 17'($signed(item.logit) - $signed(max_q));
		else diff = 17'($signed(max_q) - $signed(item.logit));
		t_prod = 34'(diff) * 34'(LOG2E_Q16);
		ip     = t_prod[33:24];
		eidx   = t_prod[23:24-EXP_IDX_W];
		e_val  = (ip > 10'd16) ? 17'd0 : (exp_rom[eidx] >> ip);
	end

	// rescale path
	logic [56:0] mul;
	logic [57:0] nsum;
	always_comb begin
		mul = 57'(sum_q) * 57'(e_q);
		if (up_q) nsum = 58'(mul[56:16]) + 58'(ONE_Q16);
		else nsum = 58'(sum_q) + 58'(e_q);
	end

	// leading one and ln table, from the sum after its update
	logic [4:0] p;
	logic [39:0] nrm;
	always_comb begin
		p = 5'd0;
		for (int i = 16; i < 40; i++) if (sum_q[i]) p = 5'(i - 16);
		nrm = sum_q << (5'd23 - p);
	end

	logic [32:0] l2;
	logic [57:0] lnp;
	logic [15:0] lnq8;
	logic signed [25:0] lp;
	logic signed [23:0] lp_sat;
	logic signed [32:0] tsum;
	always_comb begin
		l2   = 33'({p, 24'd0}) + 33'(ln_rom[nrm[38:31]]);
		lnp  = 58'(ln_prod_q);
		lnq8 = lnp[47:32];
		lp   = 26'(tgt_q) - 26'(max_q) - 26'(lnq8);
		if (lp > 0) lp_sat = '0;
		else if (lp < -26'sd8388608) lp_sat = -24'sd8388608;
		else lp_sat = lp[23:0];
		tsum = 33'(total_q) + 33'(lp_sat);
	end
	logic bad;
	assign bad = cur_q.bad_tgt || !seen_q;

	logic load;
	always_comb begin
		st_d = st_q;
		pop  = 1'b0;
		load = 1'b0;
		case (st_q)
			BK_IDLE: if (!qstat.empty) begin
				pop  = 1'b1;
				load = 1'b1;
				st_d = BK_EXP;
			end
			BK_EXP:  st_d = cur_q.row_end ? BK_LN : BK_IDLE;
			BK_LN:   st_d = BK_OUT;
			BK_OUT:  if (!out_ch.valid) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= BK_IDLE;
		else st_q <= st_d;
	end

	// item capture on load; ln(2) product with rounding half
	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= item;
			e_q   <= e_val;
			up_q  <= $signed(item.logit) > max_q;
		end
		if (st_q == BK_LN) ln_prod_q <= 57'(l2) * 57'(LN2_Q16) + (57'd1 << 31);
	end

	// row state update and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= -16'sd32768;
			sum_q   <= '0;
			tgt_q   <= '0;
			seen_q  <= 1'b0;
			total_q <= '0;
			out_ch.valid <= 1'b0;
			out_ch.row_logprob <= '0;
			out_ch.total_logprob <= '0;
			out_ch.target_out_of_range <= 1'b0;
			out_ch.last <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			if (st_q == BK_EXP) begin
				if (cur_q.first) begin
					max_q <= cur_q.logit;
					sum_q <= 40'(ONE_Q16);
					tgt_q <= cur_q.hit ? cur_q.logit : 16'sd0;
					seen_q <= cur_q.hit;
				end else begin
					if (up_q) max_q <= cur_q.logit;
					sum_q <= (nsum > 58'(SUM_MAX)) ? SUM_MAX : nsum[SUM_W-1:0];
					if (cur_q.hit) begin
						tgt_q  <= cur_q.logit;
						seen_q <= 1'b1;
					end
				end
			end
			if (st_q == BK_OUT && !out_ch.valid) begin
				out_ch.valid <= 1'b1;
				out_ch.target_out_of_range <= bad;
				out_ch.last <= cur_q.last_row;
				out_ch.row_logprob <= bad ? 24'sd0 : lp_sat;
				if (bad) begin
					out_ch.total_logprob <= total_q;
				end else if (tsum < -33'sd2147483648) begin
					out_ch.total_logprob <= 32'sh80000000;
				end else begin
					out_ch.total_logprob <= tsum[31:0];
				end
				if (cur_q.last_row) total_q <= '0;
				else if (!bad) total_q <= (tsum < -33'sd2147483648) ? 32'sh80000000 : tsum[31:0];
			end
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("result dropped");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> st_q == BK_IDLE)
		else $error("pop while busy");
	a_lp_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.row_logprob <= 0)
		else $error("positive log-probability");

endmodule
`default_nettype wire

/* hw/rtl/log_softmax_token_logprob_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// log_softmax_token_logprob_core: token log-likelihood top level
// Front intake, queue, back log-sum-exp datapath and APB register.
// ----------------------------------------------------------------------------
// The queue holds each item until the back pops it in IDLE; EXP updates
// the exp sum, and a row end goes on through LN (ln product) and OUT (result).
// The back takes one item at a time; OUT waits while the last result is unread.
// Reset: arst_n clears control, running state and vocab_size (32000).
module log_softmax_token_logprob_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lsm_in_if.sink           in_ch,
	lsm_out_if.source        out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import lsm_pkg::*;

	logic [VOCAB_W-1:0] vocab_q;
	lsm_item_t  f_item, q_item;
	lsm_qstat_t qstat;
	logic push, pop;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_VOCAB) ? 32'(vocab_q) : 32'd0;

	// vocab_size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vocab_q <= VOCAB_RESET;
		else if (psel && penable && pwrite && paddr == REG_VOCAB) vocab_q <= pwdata[VOCAB_W-1:0];
	end

	lsm_front u_front (.clk, .arst_n, .in_ch, .vocab_size(vocab_q), .qstat,
		.item(f_item), .push);
	lsm_queue u_queue (.clk, .arst_n, .push, .wdata(f_item), .pop, .rdata(q_item), .qstat);
	lsm_back u_back (.clk, .arst_n, .item(q_item), .qstat, .pop, .out_ch);

endmodule
`default_nettype wire

/* bench/tb_lsm_checker.sv */
// ----------------------------------------------------------------------------
// tb_lsm_checker: token log-likelihood scoreboard
// Watches the item and result channels, runs an online log-sum-exp predictor
// at the block's widths and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module tb_lsm_checker
	import lsm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	lsm_in_if               in_ch,
	lsm_out_if              out_ch,
	input  wire logic       psel,
	input  wire logic       penable,
	input  wire logic       pwrite,
	input  wire logic [1:0] paddr,
	input  wire logic [31:0] pwdata,
	output int              err_count,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [23:0] row_lp;
		logic signed [31:0] total_lp;
		logic               oor;
		logic               last;
	} row_score_t;

	row_score_t score_q[$];

	logic [16:0] exp_lut[EXP_TABLE_DEPTH];
	logic [23:0] log2_lut[256];

	// predictor state
	logic [VOCAB_W-1:0] row_len;
	logic signed [15:0] max_q8;
	logic [SUM_W-1:0]   sum_q16;
	logic signed [15:0] tgt_q8;
	logic [IDX_W-1:0]   elem_idx;
	logic signed [31:0] seq_total;
	logic               tgt_seen;

	assign pending = score_q.size();

	// exp(-d/256) in Q16
	function automatic logic [16:0] exp_of_neg(input logic [16:0] d);
		logic [63:0] t, fr, idx;
		logic [5:0]  ip;
		t = 64'(d) * 64'd94548;
		if ((t >> 24) > 16) return '0;
		ip = 6'(t >> 24);
		fr = t & 64'hFFFFFF;
		idx = (fr * EXP_TABLE_DEPTH) >> 24;
		if (idx >= EXP_TABLE_DEPTH) idx = EXP_TABLE_DEPTH - 1;
		return exp_lut[idx] >> ip;
	endfunction

	// ln(s/65536) in Q8
	function automatic logic [31:0] ln_of_sum(input logic [SUM_W-1:0] s);
		int p;
		logic [SUM_W-1:0] n;
		logic [63:0] l2, prod;
		if (s < 40'd65536) return '0;
		p = 39;
		while (p > 16 && !s[p]) p--;
		n = s << (39 - p);
		l2 = (64'(p - 16) << 24) + 64'(log2_lut[n[38:31]]);
		prod = (l2 * 64'd45426 + (64'd1 << 31)) >> 32;
		return prod[31:0];
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("tb_lsm_checker: %s mismatch got %0h want %0h at %0t", what, got, want, $time);
		err_count++;
	endtask

	task automatic take_logit(input logic signed [15:0] x, input logic [17:0] tgt,
		input logic lastr);
		logic [18:0] vlen;
		logic [SUM_W+16:0] prod;
		logic [SUM_W:0] acc;
		logic bad;
		logic signed [63:0] lp, t;
		row_score_t sc;
		vlen = (row_len < 1) ? 19'd1 : row_len;
		if (vlen > 19'(MAX_VOCAB)) vlen = 19'(MAX_VOCAB);
		if (elem_idx == 0) begin
			max_q8 = x;
			sum_q16 = 40'd65536;
			tgt_q8 = 0;
			tgt_seen = 0;
		end else if (x > max_q8) begin
			prod = (57'(sum_q16) * 57'(exp_of_neg(17'(32'(x) - 32'(max_q8))))) >> 16;
			prod = prod + 57'd65536;
			sum_q16 = (prod > 57'(SUM_MAX)) ? SUM_MAX : prod[SUM_W-1:0];
			max_q8 = x;
		end else begin
			acc = 41'(sum_q16) + 41'(exp_of_neg(17'(32'(max_q8) - 32'(x))));
			sum_q16 = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
		end
		if (32'(elem_idx) == 32'(tgt)) begin
			tgt_q8 = x;
			tgt_seen = 1;
		end
		if (32'(elem_idx) + 1 < 32'(vlen)) begin
			elem_idx = elem_idx + 1;
			return;
		end
		elem_idx = 0;
		bad = (32'(tgt) >= 32'(vlen)) || !tgt_seen;
		lp = 0;
		if (!bad) begin
			lp = 64'(tgt_q8) - 64'(max_q8) - 64'(ln_of_sum(sum_q16));
			if (lp > 0) lp = 0;
			if (lp < -64'sd8388608) lp = -64'sd8388608;
			t = 64'(seq_total) + lp;
			if (t < -64'sd2147483648) t = -64'sd2147483648;
			seq_total = t[31:0];
		end
		sc.row_lp = lp[23:0];
		sc.total_lp = seq_total;
		sc.oor = bad;
		sc.last = lastr;
		score_q.push_back(sc);
		if (lastr) seq_total = 0;
	endtask

	initial begin
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
			logic [63:0] y, term, acc;
			y = (64'(k) * 64'd744261118) / EXP_TABLE_DEPTH;
			term = 64'd1 << 30;
			acc = term;
			for (int n = 1; n <= 13; n++) begin
				term = ((term * y) >> 30) / n;
				acc = (n % 2) ? acc - term : acc + term;
			end
			if (acc[63]) acc = 0;
			exp_lut[k] = 17'((acc + 64'd8192) >> 14);
		end
		for (int k = 0; k < 256; k++) begin
			logic [63:0] x;
			x = 64'(256 + k) << 22;
			log2_lut[k] = '0;
			for (int i = 0; i < 24; i++) begin
				x = (x * x) >> 30;
				if (x >= (64'd2 << 30)) begin
					x = x >> 1;
					log2_lut[k][23-i] = 1'b1;
				end
			end
		end
	end

	// watch transfers and register writes
	always @(posedge clk or negedge arst_n) begin
		row_score_t got, want;
		if (!arst_n) begin
			err_count = 0;
			score_q.delete();
			row_len = VOCAB_RESET;
			max_q8 = -16'sd32768;
			sum_q16 = '0;
			tgt_q8 = 0;
			elem_idx = 0;
			seq_total = 0;
			tgt_seen = 0;
		end else begin
			if (psel && penable && pwrite && paddr == REG_VOCAB)
				row_len = pwdata[VOCAB_W-1:0];
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.row_logprob, out_ch.total_logprob,
					out_ch.target_out_of_range, out_ch.last};
				if (score_q.size() == 0) begin
					$display("tb_lsm_checker: result transfer with none expected at %0t", $time);
					err_count++;
				end else begin
					want = score_q.pop_front();
					if (got.row_lp !== want.row_lp) report("row_logprob", got.row_lp, want.row_lp);
					if (got.total_lp !== want.total_lp)
						report("total_logprob", got.total_lp, want.total_lp);
					if (got.oor !== want.oor) report("target_out_of_range", got.oor, want.oor);
					if (got.last !== want.last) report("last", got.last, want.last);
				end
			end
			if (in_ch.valid && in_ch.ready)
				take_logit(in_ch.logit, in_ch.target_token, in_ch.last_row);
		end
	end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: token log-likelihood bench
// Directed rows then random rows over several row lengths, with random gaps
// on both channels; the checker scores every result transfer.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lsm_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	int          err_count, pending;
	int          idle_cycles;
	int          items_sent;

	lsm_in_if  in_ch();
	lsm_out_if out_ch();

	log_softmax_token_logprob_core dut (
		.clk, .arst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	tb_lsm_checker chk (
		.clk, .arst_n, .in_ch, .out_ch, .psel, .penable, .pwrite, .paddr, .pwdata,
		.err_count, .pending
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// result side stalls
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < 3) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(5, 40)) @(posedge clk);
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) < 70);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// valid drops only for a gap, so back-to-back items keep it high
	task automatic send_logit(input logic signed [15:0] x, input logic [17:0] tgt,
		input logic lastr);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			in_ch.logit <= 16'($urandom);
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.logit <= x;
		in_ch.target_token <= tgt;
		in_ch.last_row <= lastr;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_vocab(input logic [31:0] v);
		drain();
		psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_VOCAB; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// one row; mode 0 random logits, 1 extremes
	task automatic send_row(input int len, input logic [17:0] tgt, input logic lastr,
		input bit consistent, input int mode);
		logic signed [15:0] x;
		logic [17:0] t;
		for (int i = 0; i < len; i++) begin
			case (mode)
				1: x = (i % 2) ? 16'sh7FFF : 16'sh8000;
				default: x = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
					16'(int'($urandom_range(0, 4095)) - 2048);
			endcase
			t = consistent ? tgt : 18'($urandom);
			send_logit(x, t, (i == len - 1) ? lastr : 1'($urandom));
		end
	endtask

	initial begin
		int vlen;
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_ch.valid = 0; in_ch.logit = '0; in_ch.target_token = '0; in_ch.last_row = 0;
		idle_cycles = 0;
		items_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest rows: extremes, target hits and misses
		write_vocab(32'd2);
		send_row(2, 18'd0, 1'b0, 1, 1);
		send_row(2, 18'd1, 1'b0, 1, 1);
		send_row(2, 18'd2, 1'b0, 1, 0);
		send_row(2, 18'h3FFFF, 1'b1, 1, 0);
		send_logit(16'sh7FFF, 18'd1, 0);
		send_logit(16'sh8000, 18'd0, 1);
		// zero length clamps to one
		write_vocab(32'd0);
		send_logit(16'sh8000, 18'd0, 0);
		send_logit(16'sh7FFF, 18'd1, 1);
		write_vocab(32'd5);
		send_row(5, 18'd4, 1'b1, 1, 0);
		send_row(5, 18'd3, 1'b0, 0, 0);
		// pause until all results are in
		drain();
		send_row(5, 18'd2, 1'b1, 1, 1);

		// random rows over several row lengths
		while (items_sent < 850) begin
			vlen = $urandom_range(1, 24);
			write_vocab(32'(vlen) | (32'($urandom) & 32'hFFF80000));
			repeat ($urandom_range(2, 8)) begin
				send_row(vlen, ($urandom_range(0, 9) == 0) ? 18'($urandom) :
					18'($urandom_range(0, vlen - 1)), 1'($urandom_range(0, 3) == 0),
					$urandom_range(0, 19) != 0, 0);
			end
		end
		// long sequence of steep rows: target at the bottom, other at the top
		write_vocab(32'd2);
		repeat (75) begin
			send_logit(16'sh8000, 18'd0, 0);
			send_logit(16'sh7FFF, 18'd0, 0);
		end
		// vocab above the table limit clamps; short partial row ends by shrink
		write_vocab(32'h7FFFF);
		send_row(3, 18'd1, 1'b0, 1, 0);
		in_ch.valid <= 1'b0;
		repeat (12) @(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_VOCAB; pwdata <= 32'd2;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		send_logit(16'sd0, 18'd1, 1);

		drain();
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
